// ===== rtl/tipd_pkg.sv =====
// ----------------------------------------------------------------------------
// tipd_pkg
// Shared types, constants and lookup functions of the tape image pulse
// decoder: header signature bytes, clock rate table and the command format
// passed from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

package tipd_pkg;

   localparam int unsigned HEADER_BYTES_DEFAULT = 20;
   localparam int unsigned PULSE_WIDTH_DEFAULT  = 32;
   localparam int unsigned QUEUE_DEPTH          = 2;

   localparam int unsigned SIG_BYTES   = 12;
   localparam int unsigned VALUE_WIDTH = 24;
   localparam int unsigned RATE_WIDTH  = 18;
   localparam int unsigned LEN_WIDTH   = 32;

   localparam logic [7:0]  VARIANT_CHAR   = 8'h31;
   localparam logic [23:0] V0_ZERO_PULSE  = 24'd25000;
   localparam logic [23:0] LONG_OVERFLOW  = 24'hFFFFFF;

   // Result event codes.
   localparam logic [1:0] EV_ACCEPT = 2'd0;
   localparam logic [1:0] EV_REJECT = 2'd1;
   localparam logic [1:0] EV_PULSE  = 2'd2;

   // Command codes from the front to the back.
   localparam logic [1:0] CMD_ACCEPT = 2'd0;
   localparam logic [1:0] CMD_REJECT = 2'd1;
   localparam logic [1:0] CMD_PULSE  = 2'd2;
   localparam logic [1:0] CMD_CARRY  = 2'd3;

   typedef struct packed {
      logic [1:0]             kind;
      logic [VALUE_WIDTH-1:0] value;
      logic                   half_waves;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } qpush_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   // Signature byte for either header variant.  The variants differ only
   // in the two digits after the leading letter.
   function automatic logic [7:0] sig_byte(input logic variant, input logic [3:0] idx);
      logic [7:0] b;
      unique case (idx)
         4'd0:    b = 8'h43;
         4'd1:    b = variant ? 8'h31 : 8'h36;
         4'd2:    b = variant ? 8'h36 : 8'h34;
         4'd3:    b = 8'h2D;
         4'd4:    b = 8'h54;
         4'd5:    b = 8'h41;
         4'd6:    b = 8'h50;
         4'd7:    b = 8'h45;
         4'd8:    b = 8'h2D;
         4'd9:    b = 8'h52;
         4'd10:   b = 8'h41;
         4'd11:   b = 8'h57;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Machine clock divided by 8, indexed by machine and video standard.
   function automatic logic [RATE_WIDTH-1:0] clock_rate_lookup(input logic [1:0] machine,
                                                              input logic       video);
      logic [RATE_WIDTH-1:0] r;
      unique case (machine)
         2'd0:    r = video ? 18'd127840 : 18'd123156;
         2'd1:    r = video ? 18'd127840 : 18'd138550;
         default: r = video ? 18'd111860 : 18'd110840;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tipd_req_if.sv =====
// ----------------------------------------------------------------------------
// tipd_req_if
// Input channel carrying one tape image byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tipd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] tape_byte;
   logic       first_byte;

   modport source (output valid, tape_byte, first_byte, input ready);
   modport sink   (input valid, tape_byte, first_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/tipd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tipd_rsp_if
// Result channel carrying one decoder event per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tipd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [31:0] pulse_length;
   logic [17:0] clock_rate;
   logic        half_waves;

   modport source (output valid, event_kind, pulse_length, clock_rate, half_waves,
                   input ready);
   modport sink   (input valid, event_kind, pulse_length, clock_rate, half_waves,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/tipd_front.sv =====
// ----------------------------------------------------------------------------
// tipd_front
// Header parser and byte classifier.  Turns each accepted byte into at most
// one command for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tipd_front #(
   parameter int unsigned HEADER_BYTES = tipd_pkg::HEADER_BYTES_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   tipd_req_if.sink            req_bus,
   input  wire                 q_full,
   output tipd_pkg::qpush_type q_push
);

   localparam int unsigned POS_W = $clog2(HEADER_BYTES);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_DATA   = 2'd1;
   localparam logic [1:0] PH_LONG   = 2'd2;
   localparam logic [1:0] PH_IGNORE = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             sig_ok_ff, sig_ok_in;
   logic             variant_ff, variant_in;
   logic [1:0]       version_ff, version_in;
   logic [1:0]       machine_ff, machine_in;
   logic             video_ff, video_in;
   logic [1:0]       long_cnt_ff, long_cnt_in;
   logic [15:0]      long_lo_ff, long_lo_in;
   logic             prior_zero_ff, prior_zero_in;

   logic             accept;
   logic [7:0]       b;
   logic [1:0]       phase_e;
   logic [23:0]      long_v;

   assign req_bus.ready = ~q_full;
   assign accept        = req_bus.valid & req_bus.ready;
   assign b             = req_bus.tape_byte;
   assign phase_e       = req_bus.first_byte ? PH_HEADER : phase_ff;
   assign long_v        = {b, long_lo_ff};

   always_comb begin
      phase_in      = phase_e;
      pos_in        = req_bus.first_byte ? '0 : pos_ff;
      sig_ok_in     = req_bus.first_byte ? 1'b1 : sig_ok_ff;
      variant_in    = req_bus.first_byte ? 1'b0 : variant_ff;
      version_in    = version_ff;
      machine_in    = machine_ff;
      video_in      = video_ff;
      long_cnt_in   = req_bus.first_byte ? 2'd0 : long_cnt_ff;
      long_lo_in    = long_lo_ff;
      prior_zero_in = req_bus.first_byte ? 1'b0 : prior_zero_ff;
      q_push        = '0;

      unique case (phase_e)
         PH_HEADER: begin
            if (pos_in < POS_W'(tipd_pkg::SIG_BYTES)) begin
               if (pos_in == POS_W'(1)) begin
                  variant_in = (b == tipd_pkg::VARIANT_CHAR);
               end
               if (b != tipd_pkg::sig_byte(variant_in, pos_in[3:0])) begin
                  sig_ok_in = 1'b0;
               end
            end else if (pos_in == POS_W'(12)) begin
               if (b > 8'd2) sig_ok_in = 1'b0;
               else version_in = b[1:0];
            end else if (pos_in == POS_W'(13)) begin
               if (b > 8'd2) sig_ok_in = 1'b0;
               else machine_in = b[1:0];
            end else if (pos_in == POS_W'(14)) begin
               if (b > 8'd1) sig_ok_in = 1'b0;
               else video_in = b[0];
            end
            if (pos_in == POS_W'(HEADER_BYTES - 1)) begin
               pos_in      = '0;
               q_push.push = 1'b1;
               if (sig_ok_in) begin
                  phase_in              = PH_DATA;
                  prior_zero_in         = 1'b0;
                  q_push.cmd.kind       = tipd_pkg::CMD_ACCEPT;
                  q_push.cmd.value      = tipd_pkg::VALUE_WIDTH'(
                     tipd_pkg::clock_rate_lookup(machine_in, video_in));
                  q_push.cmd.half_waves = (version_in == 2'd2);
               end else begin
                  phase_in        = PH_IGNORE;
                  q_push.cmd.kind = tipd_pkg::CMD_REJECT;
               end
            end else begin
               pos_in = pos_in + POS_W'(1);
            end
         end
         PH_DATA: begin
            if (b != 8'd0) begin
               prior_zero_in    = 1'b0;
               q_push.push      = 1'b1;
               q_push.cmd.kind  = tipd_pkg::CMD_PULSE;
               q_push.cmd.value = tipd_pkg::VALUE_WIDTH'(b);
            end else if (version_ff == 2'd0) begin
               if (!prior_zero_ff) begin
                  prior_zero_in    = 1'b1;
                  q_push.push      = 1'b1;
                  q_push.cmd.kind  = tipd_pkg::CMD_PULSE;
                  q_push.cmd.value = tipd_pkg::V0_ZERO_PULSE;
               end
            end else begin
               phase_in    = PH_LONG;
               long_cnt_in = 2'd0;
            end
         end
         PH_LONG: begin
            unique case (long_cnt_ff)
               2'd0: begin
                  long_lo_in[7:0] = b;
                  long_cnt_in     = 2'd1;
               end
               2'd1: begin
                  long_lo_in[15:8] = b;
                  long_cnt_in      = 2'd2;
               end
               default: begin
                  long_cnt_in      = 2'd0;
                  phase_in         = PH_DATA;
                  q_push.push      = 1'b1;
                  q_push.cmd.value = long_v >> 3;
                  q_push.cmd.kind  = (long_v == tipd_pkg::LONG_OVERFLOW) ?
                                     tipd_pkg::CMD_CARRY : tipd_pkg::CMD_PULSE;
               end
            endcase
         end
         default: begin
         end
      endcase

      q_push.push = q_push.push & accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         pos_ff        <= '0;
         sig_ok_ff     <= 1'b1;
         variant_ff    <= 1'b0;
         version_ff    <= 2'd0;
         machine_ff    <= 2'd0;
         video_ff      <= 1'b0;
         long_cnt_ff   <= 2'd0;
         prior_zero_ff <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         sig_ok_ff     <= sig_ok_in;
         variant_ff    <= variant_in;
         version_ff    <= version_in;
         machine_ff    <= machine_in;
         video_ff      <= video_in;
         long_cnt_ff   <= long_cnt_in;
         prior_zero_ff <= prior_zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         long_lo_ff <= long_lo_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tipd_queue.sv =====
// ----------------------------------------------------------------------------
// tipd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tipd_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  tipd_pkg::qpush_type q_push,
   input  wire                 q_pop,
   output logic                q_full,
   output tipd_pkg::qhead_type q_head
);

   localparam int unsigned DEPTH = tipd_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tipd_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign q_full       = (count_ff == CNT_W'(DEPTH));
   assign q_head.valid = (count_ff != '0);
   assign q_head.cmd   = entry_ff[rd_ptr_ff];
   assign do_pop       = q_pop & q_head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (q_push.push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!q_push.push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         entry_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push.push |-> !q_full)
      else $error("push into a full queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (q_push.push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count lost a push");

endmodule

`default_nettype wire

// ===== rtl/tipd_back.sv =====
// ----------------------------------------------------------------------------
// tipd_back
// Executes queued commands: keeps the pulse carry, saturates sums and holds
// the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tipd_back #(
   parameter int unsigned PULSE_WIDTH = tipd_pkg::PULSE_WIDTH_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  tipd_pkg::qhead_type q_head,
   output logic                q_pop,
   tipd_rsp_if.source          rsp_bus
);

   logic [PULSE_WIDTH-1:0] carry_ff, carry_in;
   logic                   out_valid_ff, out_valid_in;
   logic [1:0]             kind_ff;
   logic [31:0]            len_ff;
   logic [17:0]            rate_ff;
   logic                   hw_ff;

   logic                   is_carry;
   logic                   emit;
   logic [PULSE_WIDTH:0]   raw_sum;
   logic [PULSE_WIDTH-1:0] sat_sum;
   logic [63:0]            sum_ext;

   assign is_carry = (q_head.cmd.kind == tipd_pkg::CMD_CARRY);
   assign q_pop    = q_head.valid & (is_carry | ~out_valid_ff | rsp_bus.ready);
   assign emit     = q_pop & ~is_carry;

   assign raw_sum  = {1'b0, carry_ff} + (PULSE_WIDTH + 1)'(q_head.cmd.value);
   assign sat_sum  = raw_sum[PULSE_WIDTH] ? '1 : raw_sum[PULSE_WIDTH-1:0];
   assign sum_ext  = 64'(sat_sum);

   always_comb begin
      carry_in = carry_ff;
      if (q_pop) begin
         carry_in = is_carry ? sat_sum : '0;
      end
      out_valid_in = out_valid_ff;
      if (emit) out_valid_in = 1'b1;
      else if (rsp_bus.ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         carry_ff     <= carry_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         case (q_head.cmd.kind)
            tipd_pkg::CMD_ACCEPT: begin
               kind_ff <= tipd_pkg::EV_ACCEPT;
               len_ff  <= '0;
               rate_ff <= q_head.cmd.value[17:0];
               hw_ff   <= q_head.cmd.half_waves;
            end
            tipd_pkg::CMD_REJECT: begin
               kind_ff <= tipd_pkg::EV_REJECT;
               len_ff  <= '0;
               rate_ff <= '0;
               hw_ff   <= 1'b0;
            end
            default: begin
               kind_ff <= tipd_pkg::EV_PULSE;
               len_ff  <= sum_ext[31:0];
               rate_ff <= '0;
               hw_ff   <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.event_kind   = kind_ff;
   assign rsp_bus.pulse_length = len_ff;
   assign rsp_bus.clock_rate   = rate_ff;
   assign rsp_bus.half_waves   = hw_ff;

endmodule

`default_nettype wire

// ===== rtl/tape_image_pulse_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tape_image_pulse_decoder_core
// Checks a tape image header and turns the following bytes into pulse
// lengths, one byte per transfer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transfer carries
//   --------  ---------  ------------------------------------------------
//   req_bus   in         tape_byte, first_byte (one image byte)
//   rsp_bus   out        event_kind, pulse_length, clock_rate, half_waves
//
// A sustained rate of one byte per clock holds while rsp_bus takes results
// every cycle.  A byte transfer reaches its result through the queue entry,
// then the output register.
// Reset is synchronous and needs no clearing pass; the block takes bytes in
// the first cycle after reset.  When the two-entry command queue is full,
// req_bus.ready drops; a stall on rsp_bus reaches req_bus only through it.
//
`default_nettype none

module tape_image_pulse_decoder_core #(
   parameter int unsigned HEADER_BYTES = tipd_pkg::HEADER_BYTES_DEFAULT,
   parameter int unsigned PULSE_WIDTH  = tipd_pkg::PULSE_WIDTH_DEFAULT
) (
   input wire          clock,
   input wire          reset,
   tipd_req_if.sink    req_bus,
   tipd_rsp_if.source  rsp_bus
);

   // Front to queue: one optional command per accepted byte.
   tipd_pkg::qpush_type q_push;
   // Queue to back: oldest command and whether one is present.
   tipd_pkg::qhead_type q_head;
   logic                q_full;
   logic                q_pop;

   // The front owns header parsing, phase tracking and long value assembly.
   tipd_front #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push)
   );

   // The queue lets the front keep taking bytes while a result waits.
   tipd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_full (q_full),
      .q_head (q_head)
   );

   // The back holds the carried pulse share; a header event clears it, which
   // also drops any share left unfinished by a restart.
   tipd_back #(
      .PULSE_WIDTH (PULSE_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== verif/tape_image_pulse_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// tape_image_pulse_decoder_core_test
// Self-checking testbench of the tape image pulse decoder. Directed tests
// cover the following:
//   - header parsing right after reset
//   - short zero pulses in version 0
//   - 24-bit long values, including the overflow value carried into the
//     next pulse
//   - the half-wave flag
//   - every entry of the clock rate table
//   - rejected headers and restarts
//   - several overflow values carried up into one pulse
// A long random part follows. It is made mostly of well-formed files with
// random content, with broken and truncated headers and raw noise mixed in.
// Every accepted byte runs through a local predictor. Every result transfer
// is checked against the oldest predicted event.
// ----------------------------------------------------------------------------

module tape_image_pulse_decoder_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HDR_LEN = tipd_pkg::HEADER_BYTES_DEFAULT;

   // Both header signatures, byte 0 in the top bits. They differ only in
   // bytes 1 and 2.
   localparam logic [95:0] SIG_PLAIN = 96'h43_36_34_2D_54_41_50_45_2D_52_41_57;
   localparam logic [95:0] SIG_ALT   = 96'h43_31_36_2D_54_41_50_45_2D_52_41_57;

   // Clock rates divided by 8. Entry (machine * 2 + video) sits at bit
   // (machine * 2 + video) * 18.
   localparam logic [107:0] RATE_TABLE = {18'd111860, 18'd110840,
                                          18'd127840, 18'd138550,
                                          18'd127840, 18'd123156};

   typedef enum logic [1:0] {
      PARSE_HEADER,
      PARSE_DATA,
      PARSE_LONG,
      PARSE_IGNORE
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] len;
      logic [17:0] rate;
      logic        hw;
   } tape_event_type;

   logic clock;
   logic reset;

   tipd_req_if req_bus ();
   tipd_rsp_if rsp_bus ();

   tape_image_pulse_decoder_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predicted events that have not yet come out of the block, oldest first.
   tape_event_type  pending_events [$];

   // Predictor state. It follows the decoder one accepted byte at a time.
   parse_phase_type phase;
   logic [4:0]   hdr_pos;
   logic         sig_ok;
   logic         sig_variant;
   logic [1:0]   fmt_version;
   logic [1:0]   machine_sel;
   logic         video_sel;
   logic [1:0]   long_count;
   logic [23:0]  long_accum;
   logic [31:0]  carry_sum;
   logic         prior_zero;

   logic [7:0]   header_buf [0:HDR_LEN-1];
   int           bytes_sent;
   int           mismatch_count;
   bit           idle_on;
   int           stall_left = 0;

   // -------------------------------------------------------------------------
   // Clock, run limit and response-side back-pressure.
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // This is far beyond the slowest legal run, even with every stall at full
   // length.
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   // Result-side stalls come in random bursts while idling is on. Only one
   // assignment to ready is made per edge.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= $urandom_range(0, 7);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Predictor.
   // -------------------------------------------------------------------------
   function automatic void clear_predictor();
      phase       = PARSE_HEADER;
      hdr_pos     = '0;
      sig_ok      = 1'b1;
      sig_variant = 1'b0;
      fmt_version = '0;
      machine_sel = '0;
      video_sel   = 1'b0;
      long_count  = '0;
      long_accum  = '0;
      carry_sum   = '0;
      prior_zero  = 1'b0;
   endfunction

   // The sum clamps at the top of the 32-bit pulse range.
   function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void push_event(input logic [1:0] kind, input logic [31:0] len,
                                      input logic [17:0] rate, input logic hw);
      tape_event_type ev;
      ev.kind = kind;
      ev.len  = len;
      ev.rate = rate;
      ev.hw   = hw;
      pending_events.push_back(ev);
   endfunction

   // Emits the carried sum plus len as a pulse and clears the carry.
   function automatic void push_pulse(input logic [31:0] len);
      push_event(tipd_pkg::EV_PULSE, clamp_add(carry_sum, len), '0, 1'b0);
      carry_sum = '0;
   endfunction

   function automatic void decode_byte(input logic [7:0] value, input logic first);
      logic [95:0] sig;
      int          idx;
      if (first)
         clear_predictor();
      case (phase)
         PARSE_HEADER: begin
            if (hdr_pos < 12) begin
               // Byte 1 picks the signature that the rest is held against.
               if (hdr_pos == 1)
                  sig_variant = (value == tipd_pkg::VARIANT_CHAR);
               sig = sig_variant ? SIG_ALT : SIG_PLAIN;
               if (value != sig[95 - 8 * hdr_pos -: 8])
                  sig_ok = 1'b0;
            end else if (hdr_pos == 12) begin
               if (value > 2) sig_ok = 1'b0; else fmt_version = value[1:0];
            end else if (hdr_pos == 13) begin
               if (value > 2) sig_ok = 1'b0; else machine_sel = value[1:0];
            end else if (hdr_pos == 14) begin
               if (value > 1) sig_ok = 1'b0; else video_sel = value[0];
            end
            if (hdr_pos + 1 >= HDR_LEN) begin
               hdr_pos = '0;
               if (sig_ok) begin
                  idx   = machine_sel * 2 + video_sel;
                  phase = PARSE_DATA;
                  push_event(tipd_pkg::EV_ACCEPT, '0, RATE_TABLE[18 * idx +: 18],
                             fmt_version == 2'd2);
               end else begin
                  phase = PARSE_IGNORE;
                  push_event(tipd_pkg::EV_REJECT, '0, '0, 1'b0);
               end
            end else begin
               hdr_pos = 5'(hdr_pos + 1);
            end
         end
         PARSE_DATA: begin
            if (value != 0) begin
               prior_zero = 1'b0;
               push_pulse({24'd0, value});
            end else if (fmt_version == 0) begin
               // Only the first zero of a run gives a pulse in version 0.
               if (!prior_zero) begin
                  prior_zero = 1'b1;
                  push_pulse({8'd0, tipd_pkg::V0_ZERO_PULSE});
               end
            end else begin
               phase      = PARSE_LONG;
               long_count = '0;
               long_accum = '0;
            end
         end
         PARSE_LONG: begin
            long_accum = long_accum | (24'(value) << (8 * long_count));
            if (long_count < 2) begin
               long_count = 2'(long_count + 1);
            end else begin
               long_count = '0;
               phase      = PARSE_DATA;
               if (long_accum == tipd_pkg::LONG_OVERFLOW)
                  carry_sum = clamp_add(carry_sum, {8'd0, long_accum >> 3});
               else
                  push_pulse({8'd0, long_accum >> 3});
            end
         end
         default: ;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Result checker. Each result transfer is compared with the oldest
   // predicted event.
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin : check_events
      tape_event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d len %0d rate %0d hw %0d",
                                      rsp_bus.event_kind, rsp_bus.pulse_length,
                                      rsp_bus.clock_rate, rsp_bus.half_waves));
         end else begin
            want = pending_events.pop_front();
            if (rsp_bus.event_kind !== want.kind || rsp_bus.pulse_length !== want.len ||
                rsp_bus.clock_rate !== want.rate || rsp_bus.half_waves !== want.hw)
               report_mismatch($sformatf(
                  "expected kind %0d len %0d rate %0d hw %0d, got %0d %0d %0d %0d",
                  want.kind, want.len, want.rate, want.hw, rsp_bus.event_kind,
                  rsp_bus.pulse_length, rsp_bus.clock_rate, rsp_bus.half_waves));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------

   // Offers one byte. This may follow a random idle burst. The task returns
   // on the edge where the transfer took place. Valid stays high afterward,
   // so back-to-back bytes never lower and raise it in the same step.
   task automatic send_byte(input logic [7:0] value, input logic first);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.tape_byte  <= value;
      req_bus.first_byte <= first;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      decode_byte(value, first);
      bytes_sent++;
   endtask

   // A zero byte followed by a 24-bit little-endian value.
   task automatic send_long(input logic [23:0] value);
      send_byte(8'h00, 1'b0);
      send_byte(value[7:0], 1'b0);
      send_byte(value[15:8], 1'b0);
      send_byte(value[23:16], 1'b0);
   endtask

   // Fills the header buffer with a well-formed header. The ignored tail
   // bytes are random.
   function automatic void build_header(input logic alt, input logic [7:0] version,
                                        input logic [7:0] machine, input logic [7:0] video);
      logic [95:0] sig;
      sig = alt ? SIG_ALT : SIG_PLAIN;
      for (int i = 0; i < 12; i++)
         header_buf[i] = sig[95 - 8 * i -: 8];
      header_buf[12] = version;
      header_buf[13] = machine;
      header_buf[14] = video;
      for (int i = 15; i < HDR_LEN; i++)
         header_buf[i] = 8'($urandom_range(0, 255));
   endfunction

   // Sends the first count bytes of the header buffer. Byte 0 carries the
   // given restart flag.
   task automatic send_header(input int count, input logic first);
      for (int i = 0; i < count; i++)
         send_byte(header_buf[i], (i == 0) ? first : 1'b0);
   endtask

   // -------------------------------------------------------------------------
   // Tests.
   // -------------------------------------------------------------------------

   // After reset, the block parses a header from byte 0 without a restart
   // flag. Version 0 zero handling follows. Only the first zero of a run
   // gives the short pulse, and a nonzero byte re-arms it.
   task automatic test_header_after_reset();
      build_header(1'b0, 8'd0, 8'd0, 8'd0);
      send_header(HDR_LEN, 1'b0);
      send_byte(8'd1, 1'b0);
      send_byte(8'd255, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd128, 1'b0);
      send_byte(8'd0, 1'b0);
   endtask

   // Version 1 long values: zero, the largest regular value, and the
   // overflow value. The overflow value is carried into a short byte, into a
   // long value, and finally dropped by a restart in the middle of a long
   // value.
   task automatic test_long_values();
      build_header(1'b1, 8'd1, 8'd1, 8'd0);
      send_header(HDR_LEN, 1'b1);
      send_long(24'h000000);
      send_long(24'hFFFFFE);
      send_long(tipd_pkg::LONG_OVERFLOW);
      send_byte(8'd5, 1'b0);
      send_long(tipd_pkg::LONG_OVERFLOW);
      send_long(tipd_pkg::LONG_OVERFLOW);
      send_long(24'h000010);
      send_long(tipd_pkg::LONG_OVERFLOW);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      build_header(1'b1, 8'd1, 8'd1, 8'd0);
      send_header(HDR_LEN, 1'b1);
      send_byte(8'd9, 1'b0);
   endtask

   // Version 2 sets the half-wave flag. Its pulses decode as in version 1.
   task automatic test_half_waves();
      build_header(1'b0, 8'd2, 8'd2, 8'd1);
      send_header(HDR_LEN, 1'b1);
      send_byte(8'h80, 1'b0);
      send_long(24'h123456);
      send_byte(8'h01, 1'b0);
   endtask

   // Every machine and video standard pair, with both signature variants.
   task automatic test_rate_table();
      for (int m = 0; m < 3; m++)
         for (int v = 0; v < 2; v++) begin
            build_header(1'((m + v) % 2), 8'd0, 8'(m), 8'(v));
            send_header(HDR_LEN, 1'b1);
         end
   endtask

   // Each way a header can fail, and the bytes after a rejection being
   // ignored. The test also covers a signature that mixes the two variants
   // and a restart in the middle of a header.
   task automatic test_rejections();
      build_header(1'b0, 8'd0, 8'd0, 8'd0);
      header_buf[0] = 8'h44;
      send_header(HDR_LEN, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      build_header(1'b1, 8'd0, 8'd0, 8'd0);
      header_buf[11] = 8'h00;
      send_header(HDR_LEN, 1'b1);
      build_header(1'b1, 8'd0, 8'd0, 8'd0);
      header_buf[2] = 8'h34;
      send_header(HDR_LEN, 1'b1);
      build_header(1'b0, 8'd3, 8'd0, 8'd0);
      send_header(HDR_LEN, 1'b1);
      build_header(1'b0, 8'd255, 8'd0, 8'd0);
      send_header(HDR_LEN, 1'b1);
      build_header(1'b0, 8'd0, 8'd3, 8'd0);
      send_header(HDR_LEN, 1'b1);
      build_header(1'b0, 8'd0, 8'd0, 8'd2);
      send_header(HDR_LEN, 1'b1);
      build_header(1'b1, 8'd1, 8'd2, 8'd1);
      send_header(10, 1'b1);
      send_header(HDR_LEN, 1'b1);
   endtask

   // Several overflow values in a row add up in the carry. The following
   // byte comes out with the whole sum, and the byte after it alone.
   task automatic test_carry_accumulation();
      build_header(1'b0, 8'd1, 8'd0, 8'd1);
      send_header(HDR_LEN, 1'b1);
      repeat (6) send_long(tipd_pkg::LONG_OVERFLOW);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h03, 1'b0);
   endtask

   // Random files. Most are well formed, with random fields and random
   // pulse content. Some headers are broken or cut short, and some stretches
   // are raw noise with occasional restarts. Idling stops for the last few
   // hundred bytes.
   task automatic test_random_streams(input int target);
      int start;
      int pick;
      int count;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         if (target - (bytes_sent - start) < 300)
            idle_on = 1'b0;
         build_header(1'($urandom_range(0, 1)), 8'($urandom_range(0, 2)),
                      8'($urandom_range(0, 2)), 8'($urandom_range(0, 1)));
         pick = $urandom_range(0, 19);
         if (pick == 0)
            header_buf[$urandom_range(0, 14)] = 8'($urandom_range(0, 255));
         if (pick == 1) begin
            send_header($urandom_range(1, HDR_LEN - 1), 1'b1);
         end else if (pick == 2) begin
            repeat ($urandom_range(1, 24))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end else begin
            send_header(HDR_LEN, 1'b1);
         end
         count = $urandom_range(0, 48);
         for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 11))
               0, 1, 2, 3, 4: send_byte(8'($urandom_range(1, 255)), 1'b0);
               5, 6:          send_byte(8'h00, 1'b0);
               7:             send_long(24'($urandom_range(0, 24'hFFFFFF)));
               8:             send_long(tipd_pkg::LONG_OVERFLOW);
               9:             send_long(24'($urandom_range(0, 255)));
               10:            send_byte(8'($urandom_range(0, 255)), 1'b0);
               default: begin
                  // A zero byte and one more byte: the start of a long value in versions 1 and 2.
                  send_byte(8'h00, 1'b0);
                  send_byte(8'($urandom_range(0, 255)), 1'b0);
               end
            endcase
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.tape_byte  <= 8'h00;
      req_bus.first_byte <= 1'b0;
      bytes_sent     = 0;
      mismatch_count = 0;
      idle_on        = 1'b1;
      clear_predictor();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_header_after_reset();
      test_long_values();
      test_half_waves();
      test_rate_table();
      test_rejections();
      test_carry_accumulation();
      test_random_streams(1400);

      // Let the remaining results drain. The run limit above catches a
      // block that never delivers them.
      req_bus.valid <= 1'b0;
      idle_on = 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && pending_events.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
